### hw/rtl/cosine_similarity_nearest_match_defines.svh
// Assertion macros shared by the nearest-match checker.
`ifndef COSINE_SIMILARITY_NEAREST_MATCH_DEFINES_SVH
`define COSINE_SIMILARITY_NEAREST_MATCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/csnm_pkg.sv
// Shared types and constants of the cosine-similarity nearest-match block.
package csnm_pkg;

  localparam int SLOT_W  = 6;
  localparam int ELEM_W  = 16;
  localparam int SCORE_W = 16;
  localparam int STAT_W  = 3;
  localparam int KIND_W  = 2;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_STORED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_REMOVED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MATCH    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NO_MATCH = 3'd4;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd49152;
  localparam logic [SCORE_W-1:0] SCORE_HALF      = 16'd32768;
  localparam logic [SCORE_W-1:0] SCORE_MAX       = 16'hFFFF;
  localparam logic [SCORE_W:0]   SCORE_NEG_BASE  = 17'd32767;

  // Quotient bits needed for dot^2 * 2^30 / (n1 * n2), which never exceeds 2^30.
  localparam int QUOT_W  = 31;
  localparam int RATIO_SHIFT = 30;
  localparam int ROOT_W  = 16;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_QNORM, ST_SEEK, ST_SCORE, ST_RATIO, ST_REPORT
  } csnm_state_t;

  typedef enum logic [2:0] {
    RS_IDLE, RS_SQUARE, RS_NORMS, RS_DIVIDE, RS_ROOT, RS_DONE
  } ratio_state_t;

  typedef enum logic [1:0] {ACC_DOT, ACC_N1, ACC_N2} acc_sel_t;

endpackage

### hw/rtl/csnm_ratio.sv
// Exact score from dot product and norms: serial multiply, restoring divide, integer root.
module csnm_ratio import csnm_pkg::*; #(
  parameter int NW = 38
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [NW:0]  dot,
  input  logic [NW-1:0]       n1,
  input  logic [NW-1:0]       n2,
  output logic                done,
  output logic [SCORE_W-1:0]  score
);

  localparam int PW = 2 * NW;
  localparam int XW = PW + RATIO_SHIFT;
  localparam int CW = $clog2(NW + QUOT_W + 1);

  ratio_state_t         st_r, st_nxt;
  logic                 neg_r, neg_nxt;
  logic [PW-1:0]        mcand_r, mcand_nxt;
  logic [NW-1:0]        mplier_r, mplier_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [PW-1:0]        num_r, num_nxt;
  logic [XW-1:0]        rem_r, rem_nxt;
  logic [XW-1:0]        dvs_r, dvs_nxt;
  logic [QUOT_W-1:0]    q_r, q_nxt;
  logic [31:0]          sqv_r, sqv_nxt;
  logic [17:0]          srem_r, srem_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt;

  logic [NW-1:0]        mag;
  logic [PW-1:0]        acc_add;
  logic                 div_ge;
  logic [XW-1:0]        rem_step;
  logic [QUOT_W-1:0]    q_step;
  logic [19:0]          rt_t;
  logic [19:0]          rt_trial;
  logic                 rt_ge;
  logic [ROOT_W-1:0]    root_step;

  assign mag       = dot[NW] ? NW'(-dot) : NW'(dot);
  assign acc_add   = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign div_ge    = rem_r >= dvs_r;
  assign rem_step  = div_ge ? rem_r - dvs_r : rem_r;
  assign q_step    = {q_r[QUOT_W-2:0], div_ge};
  assign rt_t      = {srem_r, sqv_r[31:30]};
  assign rt_trial  = 20'({root_r, 2'b01});
  assign rt_ge     = rt_t >= rt_trial;
  assign root_step = {root_r[ROOT_W-2:0], rt_ge};

  // Sequencer: square the dot, multiply the norms, divide, then take the root; a zero norm skips to a zero score.
  always_comb begin
    st_nxt     = st_r;
    neg_nxt    = neg_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    q_nxt      = q_r;
    sqv_nxt    = sqv_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    score_nxt  = score_r;
    unique case (st_r)
      RS_IDLE: begin
        if (start) begin
          neg_nxt    = dot[NW];
          mcand_nxt  = PW'(mag);
          mplier_nxt = mag;
          acc_nxt    = '0;
          cnt_nxt    = CW'(NW);
          if (n1 == '0 || n2 == '0) begin
            score_nxt = '0;
            st_nxt    = RS_DONE;
          end else begin
            st_nxt = RS_SQUARE;
          end
        end
      end
      RS_SQUARE: begin
        acc_nxt    = acc_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          num_nxt    = acc_add;
          mcand_nxt  = PW'(n1);
          mplier_nxt = n2;
          acc_nxt    = '0;
          cnt_nxt    = CW'(NW);
          st_nxt     = RS_NORMS;
        end
      end
      RS_NORMS: begin
        acc_nxt    = acc_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          rem_nxt = {num_r, RATIO_SHIFT'(0)};
          dvs_nxt = {acc_add, RATIO_SHIFT'(0)};
          q_nxt   = '0;
          cnt_nxt = CW'(QUOT_W);
          st_nxt  = RS_DIVIDE;
        end
      end
      RS_DIVIDE: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          // A negative cosine needs the ceiling root, taken as floor root of q (of q-1 when exact) plus one.
          if (neg_r) begin
            sqv_nxt = {1'b0, q_step - QUOT_W'(rem_step == '0)};
          end else begin
            sqv_nxt = {1'b0, q_step};
          end
          srem_nxt = '0;
          root_nxt = '0;
          cnt_nxt  = CW'(ROOT_W);
          st_nxt   = RS_ROOT;
        end
      end
      RS_ROOT: begin
        srem_nxt = rt_ge ? 18'(rt_t - rt_trial) : 18'(rt_t);
        root_nxt = root_step;
        sqv_nxt  = sqv_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          if (neg_r) begin
            score_nxt = SCORE_W'(SCORE_NEG_BASE - {1'b0, root_step});
          end else if (root_step[ROOT_W-1]) begin
            score_nxt = SCORE_MAX;
          end else begin
            score_nxt = {1'b1, root_step[ROOT_W-2:0]};
          end
          st_nxt = RS_DONE;
        end
      end
      RS_DONE: begin
        st_nxt = RS_IDLE;
      end
      default: begin
        st_nxt = RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    q_r      <= q_nxt;
    sqv_r    <= sqv_nxt;
    srem_r   <= srem_nxt;
    root_r   <= root_nxt;
    cnt_r    <= cnt_nxt;
    score_r  <= score_nxt;
  end

  assign done  = (st_r == RS_DONE);
  assign score = score_r;

endmodule

### hw/rtl/cosine_similarity_nearest_match.sv
// Top level of the cosine-similarity nearest-match table.
// Add and query elements are taken one per cycle while no result is waiting;
// a delete answers in the next cycle. An add shorter than FEATURE_DIM then
// writes zeros to its missing elements. The last element of a query starts
// the search: the query norm first, then skipping each empty slot, and for
// each valid slot its products on the one 16x16 multiplier and then the serial
// score unit (two products, 31-step divide, 16-step root). Input is not ready
// during the zero fill or the search.
module cosine_similarity_nearest_match import csnm_pkg::*; #(
  parameter int NUM_ENTRIES = 64,
  parameter int FEATURE_DIM = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // slot[5:0], element[21:6], zero pad
  input  logic [KIND_W-1:0]   in_tuser,   // kind[1:0]
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // best_slot[5:0], best_score[21:6], zero pad
  output logic [STAT_W-1:0]   out_tuser,  // status[2:0]
  input  logic                cfg_wr_en,
  input  logic [SCORE_W-1:0]  cfg_wr_data
);

  localparam int EB  = $clog2(NUM_ENTRIES);
  localparam int ECW = $clog2(NUM_ENTRIES + 1);
  localparam int IB  = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
  localparam int ICW = $clog2(FEATURE_DIM + 1);
  localparam int AW  = $clog2(NUM_ENTRIES * FEATURE_DIM);
  localparam int NW  = 31 + $clog2(FEATURE_DIM);
  localparam int DW  = NW + 1;

  // Storage.
  logic [ELEM_W-1:0] fstore_mem [NUM_ENTRIES*FEATURE_DIM];
  logic [ELEM_W-1:0] qbuf_mem   [FEATURE_DIM];

  csnm_state_t           state_r, state_nxt;
  logic                  vec_active_r, vec_active_nxt;
  logic [KIND_W-1:0]     vec_kind_r, vec_kind_nxt;
  logic [ICW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  logic                  discard_r, discard_nxt;
  logic [EB-1:0]         pend_r, pend_nxt;
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [SCORE_W-1:0]    thr_r;
  logic [ICW-1:0]        qlen_r, qlen_nxt;
  logic [ICW-1:0]        idx_r, idx_nxt;
  logic [1:0]            ph_r, ph_nxt;
  logic [ECW-1:0]        ent_r, ent_nxt;
  logic signed [DW-1:0]  dot_r, dot_nxt;
  logic [NW-1:0]         n1_r, n1_nxt;
  logic [NW-1:0]         n2_r, n2_nxt;
  logic signed [31:0]    prod_r;
  logic                  pv_r, pv_nxt;
  acc_sel_t              ptag_r, ptag_nxt;
  logic                  qz_r, qz_nxt;
  logic [ELEM_W-1:0]     q_rd_r;
  logic [ELEM_W-1:0]     f_rd_r;
  logic [SCORE_W-1:0]    best_r, best_nxt;
  logic [EB-1:0]         best_slot_r, best_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [SCORE_W-1:0]    out_score_r, out_score_nxt;

  // Memory ports.
  logic                  f_we, f_re, q_we, q_re;
  logic [AW-1:0]         f_waddr, f_raddr;
  logic [ELEM_W-1:0]     f_wdata;
  logic [IB-1:0]         q_waddr;

  // Shared multiplier.
  logic                  mul_go;
  logic signed [15:0]    mul_a, mul_b, q_val;
  logic signed [31:0]    mul_p;

  // Score unit.
  logic                  r_start, r_done;
  logic [SCORE_W-1:0]    r_score;

  // Input decode.
  logic                  acc_in, out_free, fresh, slot_ok, disc_eff, room;
  logic [SLOT_W-1:0]     slot_in;
  logic [ELEM_W-1:0]     elem_in;
  logic [EB-1:0]         slot_idx, pend_eff;
  logic [ICW-1:0]        cnt_eff, cnt_new;
  logic [AW-1:0]         base_eff;

  assign slot_in  = in_tdata[SLOT_W-1:0];
  assign elem_in  = in_tdata[SLOT_W+ELEM_W-1:SLOT_W];
  assign slot_idx = EB'(slot_in);
  assign slot_ok  = 32'(slot_in) < 32'(NUM_ENTRIES);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc_in   = in_tvalid && in_tready;
  assign fresh    = !vec_active_r || (vec_kind_r != in_tuser);
  assign cnt_eff  = fresh ? '0 : cnt_r;
  assign disc_eff = fresh ? (!slot_ok || valid_r[slot_idx]) : discard_r;
  assign pend_eff = fresh ? slot_idx : pend_r;
  assign base_eff = fresh ? AW'(AW'(slot_idx) * AW'(FEATURE_DIM)) : base_r;
  assign room     = cnt_eff < ICW'(FEATURE_DIM);
  assign cnt_new  = room ? cnt_eff + 1'b1 : cnt_eff;

  assign q_val = qz_r ? '0 : q_rd_r;
  assign mul_p = mul_a * mul_b;
  assign f_raddr = base_r + AW'(idx_r);

  // Sequencer, accumulators and output register.
  always_comb begin
    state_nxt      = state_r;
    vec_active_nxt = vec_active_r;
    vec_kind_nxt   = vec_kind_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    discard_nxt    = discard_r;
    pend_nxt       = pend_r;
    valid_nxt      = valid_r;
    qlen_nxt       = qlen_r;
    idx_nxt        = idx_r;
    ph_nxt         = ph_r;
    ent_nxt        = ent_r;
    dot_nxt        = dot_r;
    n1_nxt         = n1_r;
    n2_nxt         = n2_r;
    qz_nxt         = qz_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_score_nxt  = out_score_r;
    f_we = 1'b0; f_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
    f_waddr = base_r + AW'(idx_r);
    f_wdata = '0;
    q_waddr = IB'(cnt_eff);
    mul_go = 1'b0; mul_a = '0; mul_b = '0; ptag_nxt = ptag_r;
    r_start = 1'b0;

    // Fold in the product registered last cycle.
    if (pv_r) begin
      unique case (ptag_r)
        ACC_DOT: dot_nxt = dot_r + DW'(prod_r);
        ACC_N1:  n1_nxt  = n1_r + NW'($unsigned(prod_r));
        ACC_N2:  n2_nxt  = n2_r + NW'($unsigned(prod_r));
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_tuser == KIND_DEL) begin
            vec_active_nxt = 1'b0;
            cnt_nxt        = '0;
            if (slot_ok) valid_nxt[slot_idx] = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_REMOVED;
            out_slot_nxt   = '0;
            out_score_nxt  = '0;
          end else if (in_tuser == KIND_ADD || in_tuser == KIND_QUERY) begin
            vec_active_nxt = 1'b1;
            vec_kind_nxt   = in_tuser;
            cnt_nxt        = cnt_new;
            if (in_tuser == KIND_ADD) begin
              pend_nxt    = pend_eff;
              discard_nxt = disc_eff;
              base_nxt    = base_eff;
              f_waddr     = base_eff + AW'(cnt_eff);
              f_wdata     = elem_in;
              f_we        = room && !disc_eff;
            end else begin
              q_we = room;
            end
            if (in_tlast) begin
              vec_active_nxt = 1'b0;
              cnt_nxt        = '0;
              if (in_tuser == KIND_QUERY) begin
                qlen_nxt      = cnt_new;
                idx_nxt       = '0;
                ph_nxt        = '0;
                n2_nxt        = '0;
                best_nxt      = '0;
                best_slot_nxt = '0;
                ent_nxt       = '0;
                state_nxt     = ST_QNORM;
              end else if (disc_eff) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_IGNORED;
                out_slot_nxt   = '0;
                out_score_nxt  = '0;
              end else if (cnt_new < ICW'(FEATURE_DIM)) begin
                idx_nxt   = cnt_new;
                state_nxt = ST_FILL;
              end else begin
                valid_nxt[pend_eff] = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_STORED;
                out_slot_nxt   = '0;
                out_score_nxt  = '0;
              end
            end
          end
        end
      end
      // Zero the tail of a short add vector, then report it stored.
      ST_FILL: begin
        if (idx_r < ICW'(FEATURE_DIM)) begin
          f_we    = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (out_free) begin
          valid_nxt[pend_r] = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_STORED;
          out_slot_nxt   = '0;
          out_score_nxt  = '0;
          state_nxt      = ST_IDLE;
        end
      end
      // Query norm: read, then square.
      ST_QNORM: begin
        if (ph_r == 2'd0) begin
          if (idx_r < ICW'(FEATURE_DIM)) begin
            q_re    = 1'b1;
            qz_nxt  = idx_r >= qlen_r;
            ph_nxt  = 2'd1;
          end else if (!pv_r) begin
            state_nxt = ST_SEEK;
          end
        end else begin
          mul_go   = 1'b1;
          mul_a    = q_val;
          mul_b    = q_val;
          ptag_nxt = ACC_N2;
          idx_nxt  = idx_r + 1'b1;
          ph_nxt   = 2'd0;
        end
      end
      // Step to the next valid slot, or to the report after the last slot.
      ST_SEEK: begin
        if (ent_r == ECW'(NUM_ENTRIES)) begin
          state_nxt = ST_REPORT;
        end else if (valid_r[EB'(ent_r)]) begin
          base_nxt  = AW'(AW'(ent_r) * AW'(FEATURE_DIM));
          idx_nxt   = '0;
          ph_nxt    = '0;
          dot_nxt   = '0;
          n1_nxt    = '0;
          state_nxt = ST_SCORE;
        end else begin
          ent_nxt = ent_r + 1'b1;
        end
      end
      // Per element: read both, multiply stored by query, then stored by itself.
      ST_SCORE: begin
        unique case (ph_r)
          2'd0: begin
            if (idx_r < ICW'(FEATURE_DIM)) begin
              f_re   = 1'b1;
              q_re   = 1'b1;
              qz_nxt = idx_r >= qlen_r;
              ph_nxt = 2'd1;
            end else if (!pv_r) begin
              r_start   = 1'b1;
              state_nxt = ST_RATIO;
            end
          end
          2'd1: begin
            mul_go   = 1'b1;
            mul_a    = f_rd_r;
            mul_b    = q_val;
            ptag_nxt = ACC_DOT;
            ph_nxt   = 2'd2;
          end
          default: begin
            mul_go   = 1'b1;
            mul_a    = f_rd_r;
            mul_b    = f_rd_r;
            ptag_nxt = ACC_N1;
            idx_nxt  = idx_r + 1'b1;
            ph_nxt   = 2'd0;
          end
        endcase
      end
      ST_RATIO: begin
        if (r_done) begin
          if (r_score > best_r) begin
            best_nxt      = r_score;
            best_slot_nxt = EB'(ent_r);
          end
          ent_nxt   = ent_r + 1'b1;
          state_nxt = ST_SEEK;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (best_r != '0 && best_r >= thr_r) ? STAT_MATCH : STAT_NO_MATCH;
          out_slot_nxt   = SLOT_W'(best_slot_r);
          out_score_nxt  = best_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    pv_nxt = mul_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vec_active_r <= 1'b0;
      vec_kind_r   <= KIND_ADD;
      cnt_r        <= '0;
      discard_r    <= 1'b0;
      pend_r       <= '0;
      valid_r      <= '0;
      thr_r        <= THRESHOLD_RESET;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vec_active_r <= vec_active_nxt;
      vec_kind_r   <= vec_kind_nxt;
      cnt_r        <= cnt_nxt;
      discard_r    <= discard_nxt;
      pend_r       <= pend_nxt;
      valid_r      <= valid_nxt;
      pv_r         <= pv_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) thr_r <= cfg_wr_data;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    qlen_r       <= qlen_nxt;
    idx_r        <= idx_nxt;
    ph_r         <= ph_nxt;
    ent_r        <= ent_nxt;
    dot_r        <= dot_nxt;
    n1_r         <= n1_nxt;
    n2_r         <= n2_nxt;
    prod_r       <= mul_p;
    ptag_r       <= ptag_nxt;
    qz_r         <= qz_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_score_r  <= out_score_nxt;
  end

  // Feature store and query buffer, registered reads.
  always_ff @(posedge clk) begin
    if (f_we) fstore_mem[f_waddr] <= f_wdata;
    if (f_re) f_rd_r <= fstore_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) qbuf_mem[q_waddr] <= elem_in;
    if (q_re) q_rd_r <= qbuf_mem[IB'(idx_r)];
  end

  csnm_ratio #(
    .NW (NW)
  ) u_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .start (r_start),
    .dot   (dot_r),
    .n1    (n1_r),
    .n2    (n2_r),
    .done  (r_done),
    .score (r_score)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_score_r, out_slot_r};

endmodule

### hw/rtl/csnm_checker.sv
// Port-level checks of the nearest-match block, bound to its top level.
`include "cosine_similarity_nearest_match_defines.svh"

module csnm_checker import csnm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [KIND_W-1:0]   in_tuser,
  input logic                in_tlast,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [23:0]         out_tdata,
  input logic [STAT_W-1:0]   out_tuser
);

  // A stalled result keeps its contents.
  `CSNM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A delete answers in the following cycle.
  `CSNM_ASSERT_NEXT(a_del_answer, in_tvalid && in_tready && in_tuser == KIND_DEL, out_tvalid && out_tuser == STAT_REMOVED, "delete did not answer removed")

  // Add and delete results carry no slot and no score.
  `CSNM_ASSERT_NOW(a_plain_zero, out_tvalid && (out_tuser == STAT_STORED || out_tuser == STAT_REMOVED || out_tuser == STAT_IGNORED), out_tdata == '0, "add or delete result carries data")

  // The search holds off input after the last query element.
  `CSNM_ASSERT_NEXT(a_query_busy, in_tvalid && in_tready && in_tuser == KIND_QUERY && in_tlast, !in_tready, "input ready during search")

endmodule

bind cosine_similarity_nearest_match csnm_checker u_csnm_checker (.*);

### bench/cosine_similarity_nearest_match_tb.sv
// Self-checking testbench for the cosine-similarity nearest-match table.
module cosine_similarity_nearest_match_tb;
  import csnm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 64;
  localparam int FEATURE_DIM = 128;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [SCORE_W-1:0] score;
  } match_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [23:0]         in_tdata;
  logic [KIND_W-1:0]   in_tuser;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [23:0]         out_tdata;
  logic [STAT_W-1:0]   out_tuser;
  logic                cfg_wr_en;
  logic [SCORE_W-1:0]  cfg_wr_data;

  // Shadow copy of the table used to work out expected results.
  logic signed [15:0]  vec_table [NUM_ENTRIES][FEATURE_DIM];
  bit                  slot_used [NUM_ENTRIES];
  logic signed [15:0]  probe_vec [FEATURE_DIM];
  int                  fill_count;
  logic [SLOT_W-1:0]   fill_slot;
  bit                  fill_drop;
  bit                  vec_open;
  logic [KIND_W-1:0]   vec_kind;
  logic [SCORE_W-1:0]  threshold;

  match_result_t       pending_results[$];
  int                  error_count;
  int                  items_sent;
  bit                  calm;
  bit                  hold_request;
  int                  hold_len;
  logic signed [15:0]  elem_buf[$];

  cosine_similarity_nearest_match #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .FEATURE_DIM(FEATURE_DIM)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("cosine_similarity_nearest_match_tb: done, errors");
    $finish;
  end

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // True when s * sqrt(n1*n2) <= 32768 * dot, decided on squares.
  function automatic bit score_fits(longint s, longint dot, longint n1, longint n2);
    logic [127:0] ws, wd, w1, w2, lhs, rhs;
    if (s <= 0 && dot >= 0) return 1'b1;
    if (s > 0 && dot <= 0) return 1'b0;
    ws = 128'((s < 0) ? -s : s);
    wd = 128'((dot < 0) ? -dot : dot);
    w1 = 128'(n1);
    w2 = 128'(n2);
    lhs = ws * ws * w1 * w2;
    rhs = (wd * wd) << 30;
    if (s > 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  // Cosine score of one stored vector against the probe vector.
  function automatic logic [SCORE_W-1:0] cosine_score(int e);
    longint dot, n1, n2, a, b, lo, hi, mid;
    dot = 0; n1 = 0; n2 = 0;
    for (int i = 0; i < FEATURE_DIM; i++) begin
      a = vec_table[e][i];
      b = probe_vec[i];
      dot += a * b;
      n1 += a * a;
      n2 += b * b;
    end
    if (n1 == 0 || n2 == 0) return '0;
    lo = -32768;
    hi = 32769;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (score_fits(mid, dot, n1, n2)) lo = mid;
      else hi = mid;
    end
    if (lo + 32768 > 65535) return SCORE_MAX;
    return SCORE_W'(lo + 32768);
  endfunction

  // Update the shadow table with one accepted item and queue its result, if it has one.
  task automatic apply_item(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                            logic signed [15:0] elem, logic last);
    match_result_t res;
    logic [SCORE_W-1:0] best, sc;
    logic [SLOT_W-1:0] best_slot;
    bit chosen;
    res = '0;
    if (kind == KIND_UNUSED) return;
    if (kind == KIND_DEL) begin
      vec_open = 1'b0;
      fill_count = 0;
      slot_used[slot] = 1'b0;
      res.status = STAT_REMOVED;
      pending_results.push_back(res);
      return;
    end
    if (vec_open && vec_kind != kind) vec_open = 1'b0;
    if (!vec_open) begin
      vec_open = 1'b1;
      vec_kind = kind;
      fill_count = 0;
      if (kind == KIND_ADD) begin
        fill_slot = slot;
        fill_drop = slot_used[slot];
      end
    end
    if (fill_count < FEATURE_DIM) begin
      if (kind == KIND_QUERY) probe_vec[fill_count] = elem;
      else if (!fill_drop) vec_table[fill_slot][fill_count] = elem;
      fill_count++;
    end
    if (!last) return;
    for (int i = fill_count; i < FEATURE_DIM; i++) begin
      if (kind == KIND_QUERY) probe_vec[i] = '0;
      else if (!fill_drop) vec_table[fill_slot][i] = '0;
    end
    vec_open = 1'b0;
    fill_count = 0;
    if (kind == KIND_ADD) begin
      if (fill_drop) begin
        res.status = STAT_IGNORED;
      end else begin
        slot_used[fill_slot] = 1'b1;
        res.status = STAT_STORED;
      end
      pending_results.push_back(res);
      return;
    end
    best = '0;
    best_slot = '0;
    chosen = 1'b0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (slot_used[e]) begin
        sc = cosine_score(e);
        if (sc > best) begin
          best = sc;
          best_slot = SLOT_W'(e);
          chosen = 1'b1;
        end
      end
    end
    res.status = (chosen && best >= threshold) ? STAT_MATCH : STAT_NO_MATCH;
    res.slot = best_slot;
    res.score = best;
    pending_results.push_back(res);
  endtask

  // Offer one item and wait until it is accepted.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                           logic signed [15:0] elem, logic last);
    int n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {2'b00, elem, slot};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    apply_item(kind, slot, elem, last);
    items_sent++;
  endtask

  // Send the elements in elem_buf as one vector, last on the final one.
  task automatic send_vector(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot);
    for (int i = 0; i < elem_buf.size(); i++)
      send_item(kind, slot, elem_buf[i], i == elem_buf.size() - 1);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fill_random(int n);
    elem_buf.delete();
    repeat (n) elem_buf.push_back(rand_elem());
  endtask

  // Wait until every expected result is in and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [SCORE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    threshold = value;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tdata[5:0] !== want.slot) report_mismatch("best_slot", out_tdata[5:0], want.slot);
        if (out_tdata[21:6] !== want.score)
          report_mismatch("best_score", out_tdata[21:6], want.score);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = hold_len;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall = gap_len();
      end
    end
  end

  // A vector stored in slot 0 must match itself with the top score.
  task automatic test_self_match();
    elem_buf = '{16'sh7FFF, 16'sh8000, 16'sd100};
    send_vector(KIND_ADD, 6'd0);
    send_vector(KIND_QUERY, 6'd0);
    drain();
  endtask

  // Occupied slots, empty deletes, long and short vectors, interruptions.
  task automatic test_special_cases();
    elem_buf = '{16'sd5};
    send_vector(KIND_ADD, 6'd0);
    send_item(KIND_DEL, 6'd40, 16'sh7FFF, 1'b0);
    elem_buf = '{16'sh8000};
    send_vector(KIND_ADD, 6'd63);
    fill_random(FEATURE_DIM + 2);
    send_vector(KIND_ADD, 6'd5);
    elem_buf = '{16'sd0, 16'sd0};
    send_vector(KIND_QUERY, 6'd0);
    send_item(KIND_UNUSED, 6'd63, 16'sh7FFF, 1'b1);
    send_item(KIND_ADD, 6'd7, 16'sd9, 1'b0);
    send_item(KIND_ADD, 6'd0, 16'sd9, 1'b0);
    send_item(KIND_DEL, 6'd7, 16'sd0, 1'b1);
    send_item(KIND_ADD, 6'd8, 16'sd3, 1'b0);
    elem_buf = '{16'sh7FFF, 16'sd1, 16'sd2};
    send_vector(KIND_QUERY, 6'd8);
    elem_buf = '{16'sh8001, 16'sh7FFF, -16'sd100};
    send_vector(KIND_QUERY, 6'd0);
    fill_random(FEATURE_DIM);
    send_vector(KIND_QUERY, 6'd0);
    drain();
  endtask

  // Threshold extremes, the midpoint and a random setting.
  task automatic test_threshold();
    logic [SCORE_W-1:0] settings [4];
    settings = '{16'd0, SCORE_MAX, SCORE_HALF, 16'($urandom)};
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      elem_buf = '{16'sh7FFF, 16'sh8000, 16'sd100};
      send_vector(KIND_QUERY, 6'd0);
      fill_random(3);
      send_vector(KIND_QUERY, 6'd0);
      drain();
    end
  endtask

  // Mostly well-formed adds, queries and deletes with random content.
  task automatic random_phase(int quota);
    int start, op, len, pick;
    logic [SLOT_W-1:0] slot;
    start = items_sent;
    while (items_sent - start < quota) begin
      op = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, 7));
      if (op < 35) begin
        fill_random(len);
        send_vector(KIND_ADD, slot);
      end else if (op < 60) begin
        pick = $urandom_range(0, 7);
        fill_random(len);
        if (slot_used[pick] && $urandom_range(0, 1))
          for (int i = 0; i < len; i++)
            elem_buf[i] = vec_table[pick][i] + 16'(int'($urandom_range(0, 6)) - 3);
        send_vector(KIND_QUERY, slot);
      end else if (op < 80) begin
        send_item(KIND_DEL, slot, rand_elem(), 1'($urandom));
      end else if (op < 85) begin
        send_item(KIND_UNUSED, slot, rand_elem(), 1'($urandom));
      end else begin
        // Broken vector: some add or query elements without last, each of random kind.
        repeat ($urandom_range(1, 3))
          send_item(($urandom_range(0, 1) != 0) ? KIND_ADD : KIND_QUERY, slot,
                    rand_elem(), 1'b0);
      end
    end
    // Close any open vector so the phase ends at a boundary.
    send_item(KIND_DEL, SLOT_W'($urandom_range(0, 7)), rand_elem(), 1'b0);
    drain();
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      write_threshold((p == 0) ? SCORE_MAX : (p == 1) ? 16'd0 : 16'($urandom));
      random_phase(30);
    end
    calm = 1'b0;
  endtask

  // The receiver holds off while deletes keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_len = 2000;
    hold_request = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(KIND_DEL, SLOT_W'($urandom_range(8, 63)), rand_elem(), 1'($urandom));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_ADD;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    items_sent = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    hold_len = 0;
    threshold = THRESHOLD_RESET;
    vec_open = 1'b0;
    vec_kind = KIND_ADD;
    fill_count = 0;
    fill_slot = '0;
    fill_drop = 1'b0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_self_match();
    test_special_cases();
    test_threshold();
    test_random_mix();
    test_backpressure();

    if (error_count == 0) begin
      $display("cosine_similarity_nearest_match_tb: done, clean");
    end else begin
      $display("cosine_similarity_nearest_match_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/csnm_pkg.sv
hw/rtl/csnm_ratio.sv
hw/rtl/cosine_similarity_nearest_match.sv
hw/rtl/csnm_checker.sv
bench/cosine_similarity_nearest_match_tb.sv
